@@ sv/jhm_pkg.sv @@
// Shared types and constants for the joint histogram block.
`timescale 1ns / 1ps
`default_nettype none

package jhm_pkg;

	// Fixed field widths of the ports
	localparam int FUNC_W       = 2;
	localparam int PCT_W        = 16;
	localparam int BIN_W        = 8;
	localparam int COUNT_PORT_W = 24;
	localparam int SUM_W        = 32;

	// Command codes
	localparam logic [FUNC_W-1:0] FUNC_OBSERVE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd2;

	// Entries between front and back
	localparam int QUEUE_DEPTH = 2;

	// Classified command as it travels from front to back
	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [BIN_W-1:0]        col;
		logic [BIN_W-1:0]        row;
		logic [COUNT_PORT_W-1:0] wval;
	} op_t;

	// Queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

@@ sv/jhm_front.sv @@
// Front end: quantizes percentages into bins, clamps indexes, saturates write counts.
`timescale 1ns / 1ps
`default_nettype none

module jhm_front #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic [jhm_pkg::FUNC_W-1:0]              func,
	input  logic signed [jhm_pkg::PCT_W-1:0]        x_percent,
	input  logic signed [jhm_pkg::PCT_W-1:0]        y_percent,
	input  logic [jhm_pkg::BIN_W-1:0]               col_select,
	input  logic [jhm_pkg::BIN_W-1:0]               row_select,
	input  logic [jhm_pkg::COUNT_PORT_W-1:0]        write_count,
	output jhm_pkg::op_t                            op
);
	import jhm_pkg::*;

	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

	// Limit a bin index to the last bin of the table
	function automatic logic [BIN_W-1:0] clamp_bin(input logic [BIN_W-1:0] b);
		logic [BIN_W-1:0] r;
		if (32'(b) >= 32'(BINS)) begin
			r = BIN_W'(BINS - 1);
		end else begin
			r = b;
		end
		return r;
	endfunction

	// Half-percent bin: zero at or below zero, odd bin for fractions in (0, 1/2]
	function automatic logic [BIN_W-1:0] pct_to_bin(input logic signed [PCT_W-1:0] v);
		logic [BIN_W-1:0] b;
		if (v <= 0) begin
			b = '0;
		end else if (v[7:0] != 8'd0 && v[7:0] <= 8'd128) begin
			b = {v[14:8], 1'b1};
		end else begin
			b = {v[14:8], 1'b0};
		end
		return clamp_bin(b);
	endfunction

	logic [COUNT_PORT_W-1:0] wval_sat;

	// Saturate an oversized write count to the cell maximum
	always_comb begin
		if (64'(write_count) > COUNT_MAX) begin
			wval_sat = COUNT_PORT_W'(COUNT_MAX);
		end else begin
			wval_sat = write_count;
		end
	end

	// Classify the command; the unused code behaves as a read
	always_comb begin
		op.wval = wval_sat;
		unique case (func)
			FUNC_OBSERVE: begin
				op.func = FUNC_OBSERVE;
				op.col  = pct_to_bin(x_percent);
				op.row  = pct_to_bin(y_percent);
			end
			FUNC_WRITE: begin
				op.func = FUNC_WRITE;
				op.col  = clamp_bin(col_select);
				op.row  = clamp_bin(row_select);
			end
			default: begin
				op.func = FUNC_READ;
				op.col  = clamp_bin(col_select);
				op.row  = clamp_bin(row_select);
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/jhm_queue.sv @@
// Short command queue between the front end and the update engine.
`timescale 1ns / 1ps
`default_nettype none

module jhm_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  jhm_pkg::op_t           din,
	input  logic                   pop,
	output jhm_pkg::op_t           dout,
	output jhm_pkg::queue_status_t status
);
	import jhm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign dout         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/jhm_back.sv @@
// Update engine: cell and total memories, read-modify-write sequencer, clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module jhm_back #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  jhm_pkg::op_t                      head,
	input  jhm_pkg::queue_status_t            qstat,
	output logic                              pop,
	output logic                              clearing,
	output logic                              done,
	output logic [jhm_pkg::BIN_W-1:0]         col_bin,
	output logic [jhm_pkg::BIN_W-1:0]         row_bin,
	output logic [jhm_pkg::COUNT_PORT_W-1:0]  cell_count,
	output logic [jhm_pkg::SUM_W-1:0]         row_sum,
	output logic [jhm_pkg::SUM_W-1:0]         column_sum,
	output logic [jhm_pkg::SUM_W-1:0]         grand_sum
);
	import jhm_pkg::*;

	localparam int IDX_W = $clog2(BINS);
	localparam int ADR_W = 2 * IDX_W;
	localparam int CELLS = 1 << ADR_W;
	localparam int ROWS  = 1 << IDX_W;
	localparam int CW    = COUNT_BITS;
	localparam logic [CW-1:0] CNT_MAX = '1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DIFF  = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	// Storage
	logic [CW-1:0]    cell_mem [CELLS];
	logic [SUM_W-1:0] row_mem  [ROWS];
	logic [SUM_W-1:0] col_mem  [ROWS];

	logic [1:0]       state_q;
	logic [ADR_W-1:0] clr_q;
	logic [SUM_W-1:0] grand_q;

	// Registered read data
	logic [CW-1:0]    cell_rd_q;
	logic [SUM_W-1:0] row_rd_q;
	logic [SUM_W-1:0] col_rd_q;

	// Pipeline of the item in flight
	op_t              op_s1;
	op_t              op_s2;
	logic [CW-1:0]    newv_s2;
	logic [SUM_W-1:0] diff_s2;

	logic [CW-1:0]    newv;
	logic [IDX_W-1:0] head_col;
	logic [IDX_W-1:0] head_row;
	logic [IDX_W-1:0] s2_col;
	logic [IDX_W-1:0] s2_row;

	logic             cell_we;
	logic [ADR_W-1:0] cell_wa;
	logic [CW-1:0]    cell_wd;
	logic             sum_we;
	logic [IDX_W-1:0] row_wa;
	logic [IDX_W-1:0] col_wa;
	logic [SUM_W-1:0] row_wd;
	logic [SUM_W-1:0] col_wd;

	logic                    done_q;
	logic [BIN_W-1:0]        col_bin_q;
	logic [BIN_W-1:0]        row_bin_q;
	logic [COUNT_PORT_W-1:0] cell_count_q;
	logic [SUM_W-1:0]        row_sum_q;
	logic [SUM_W-1:0]        col_sum_q;
	logic [SUM_W-1:0]        grand_sum_q;

	assign pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign clearing = (state_q == ST_CLEAR);
	assign head_col = IDX_W'(head.col);
	assign head_row = IDX_W'(head.row);
	assign s2_col   = IDX_W'(op_s2.col);
	assign s2_row   = IDX_W'(op_s2.row);

	// Sequencer and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read the cell and both totals for the popped beat
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1     <= head;
			cell_rd_q <= cell_mem[{head_row, head_col}];
			row_rd_q  <= row_mem[head_row];
			col_rd_q  <= col_mem[head_col];
		end
	end

	// New cell value: saturating increment, write, or unchanged for a read
	always_comb begin
		unique case (op_s1.func)
			FUNC_OBSERVE: newv = (cell_rd_q != CNT_MAX) ? cell_rd_q + CW'(1) : cell_rd_q;
			FUNC_WRITE:   newv = CW'(op_s1.wval);
			default:      newv = cell_rd_q;
		endcase
	end

	// Register new value and the difference to the old one
	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			op_s2   <= op_s1;
			newv_s2 <= newv;
			diff_s2 <= SUM_W'(newv) - SUM_W'(cell_rd_q);
		end
	end

	// Memory write ports: zero sweep after reset, otherwise write back
	always_comb begin
		cell_we = 1'b0;
		cell_wa = clr_q;
		cell_wd = '0;
		sum_we  = 1'b0;
		row_wa  = clr_q[IDX_W-1:0];
		col_wa  = clr_q[IDX_W-1:0];
		row_wd  = '0;
		col_wd  = '0;
		priority if (state_q == ST_CLEAR) begin
			cell_we = 1'b1;
			sum_we  = 1'b1;
		end else if (state_q == ST_UPD) begin
			cell_we = 1'b1;
			cell_wa = {s2_row, s2_col};
			cell_wd = newv_s2;
			sum_we  = 1'b1;
			row_wa  = s2_row;
			col_wa  = s2_col;
			row_wd  = row_rd_q + diff_s2;
			col_wd  = col_rd_q + diff_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			row_mem[row_wa] <= row_wd;
			col_mem[col_wa] <= col_wd;
		end
	end

	// Grand total wraps modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grand_q <= '0;
		end else if (state_q == ST_UPD) begin
			grand_q <= grand_q + diff_s2;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPD);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			col_bin_q    <= op_s2.col;
			row_bin_q    <= op_s2.row;
			cell_count_q <= COUNT_PORT_W'(newv_s2);
			row_sum_q    <= row_wd;
			col_sum_q    <= col_wd;
			grand_sum_q  <= grand_q + diff_s2;
		end
	end

	assign done       = done_q;
	assign col_bin    = col_bin_q;
	assign row_bin    = row_bin_q;
	assign cell_count = cell_count_q;
	assign row_sum    = row_sum_q;
	assign column_sum = col_sum_q;
	assign grand_sum  = grand_sum_q;

endmodule

`default_nettype wire

@@ sv/joint_histogram_with_marginals.sv @@
// Top level of the joint histogram with row, column and grand totals.
//
//  channel   signals                                              direction  timing
//  command   start, busy, func, x_percent, y_percent,             in         beat when start & !busy
//            col_select, row_select, write_count
//  result    done, col_bin, row_bin, cell_count, row_sum,         out        one cycle per done pulse
//            column_sum, grand_sum
//
// Each command passes through three steps in the update engine (read, difference, write back);
// the engine pops the next command only after the write back, and done is registered
// from the write-back step. After reset a sweep zeroes all memories, addressing
// 2^(2*ceil(log2 BINS)) cells (65536 at 256 bins), with busy high. A two-entry queue
// lets commands arrive while one is in flight; busy rises when it is full. The receiver
// cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module joint_histogram_with_marginals #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [jhm_pkg::FUNC_W-1:0]           func,
	input  logic signed [jhm_pkg::PCT_W-1:0]     x_percent,
	input  logic signed [jhm_pkg::PCT_W-1:0]     y_percent,
	input  logic [jhm_pkg::BIN_W-1:0]            col_select,
	input  logic [jhm_pkg::BIN_W-1:0]            row_select,
	input  logic [jhm_pkg::COUNT_PORT_W-1:0]     write_count,
	output logic                                 done,
	output logic [jhm_pkg::BIN_W-1:0]            col_bin,
	output logic [jhm_pkg::BIN_W-1:0]            row_bin,
	output logic [jhm_pkg::COUNT_PORT_W-1:0]     cell_count,
	output logic [jhm_pkg::SUM_W-1:0]            row_sum,
	output logic [jhm_pkg::SUM_W-1:0]            column_sum,
	output logic [jhm_pkg::SUM_W-1:0]            grand_sum
);
	import jhm_pkg::*;

	op_t           front_op;
	op_t           head_op;
	queue_status_t qstat;
	logic          push;
	logic          pop;
	logic          clearing;

	// Take a beat whenever the queue has room and the sweep is over
	assign busy = qstat.full || clearing;
	assign push = start && !busy;

	jhm_front #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.func        (func),
		.x_percent   (x_percent),
		.y_percent   (y_percent),
		.col_select  (col_select),
		.row_select  (row_select),
		.write_count (write_count),
		.op          (front_op)
	);

	jhm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_op),
		.pop    (pop),
		.dout   (head_op),
		.status (qstat)
	);

	jhm_back #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_op),
		.qstat      (qstat),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.col_bin    (col_bin),
		.row_bin    (row_bin),
		.cell_count (cell_count),
		.row_sum    (row_sum),
		.column_sum (column_sum),
		.grand_sum  (grand_sum)
	);

endmodule

`default_nettype wire

@@ sv/jhm_checker.sv @@
// Port-level checks on the joint histogram, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jhm_checker #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 done,
	input logic [jhm_pkg::BIN_W-1:0]            col_bin,
	input logic [jhm_pkg::BIN_W-1:0]            row_bin,
	input logic [jhm_pkg::COUNT_PORT_W-1:0]     cell_count
);
	import jhm_pkg::*;

	// Each beat holds the engine through its read, difference and write-back steps, so results never come back to back
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	// Reported bins lie inside the table
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(col_bin) < 32'(BINS)))
		else $error("column bin beyond table");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(row_bin) < 32'(BINS)))
		else $error("row bin beyond table");

	// Cell count never exceeds the counter width
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (COUNT_BITS >= COUNT_PORT_W || (32'(cell_count) >> COUNT_BITS) == 32'd0))
		else $error("cell count above counter maximum");

endmodule

bind joint_histogram_with_marginals jhm_checker #(
	.BINS       (BINS),
	.COUNT_BITS (COUNT_BITS)
) u_jhm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.col_bin     (col_bin),
	.row_bin     (row_bin),
	.cell_count  (cell_count)
);

`default_nettype wire

@@ test/joint_histogram_with_marginals_test.sv @@
// Self-checking testbench for the joint histogram with row, column and grand totals.
`timescale 1ns / 1ps

module joint_histogram_with_marginals_test;
	import jhm_pkg::*;

	localparam int BINS = 256;
	localparam logic [COUNT_PORT_W-1:0] COUNT_MAX = '1;
	// Spare command code, decoded by the block as a read
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_GAP = 24;

	// One result beat: touched cell, its count and the three totals
	typedef struct packed {
		logic [BIN_W-1:0]        col;
		logic [BIN_W-1:0]        row;
		logic [COUNT_PORT_W-1:0] cnt;
		logic [SUM_W-1:0]        rsum;
		logic [SUM_W-1:0]        csum;
		logic [SUM_W-1:0]        gsum;
	} tally_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [FUNC_W-1:0]             func;
	logic signed [PCT_W-1:0]       x_percent;
	logic signed [PCT_W-1:0]       y_percent;
	logic [BIN_W-1:0]              col_select;
	logic [BIN_W-1:0]              row_select;
	logic [COUNT_PORT_W-1:0]       write_count;
	logic                          done;
	logic [BIN_W-1:0]              col_bin;
	logic [BIN_W-1:0]              row_bin;
	logic [COUNT_PORT_W-1:0]       cell_count;
	logic [SUM_W-1:0]              row_sum;
	logic [SUM_W-1:0]              column_sum;
	logic [SUM_W-1:0]              grand_sum;

	// Shadow copy of the table and its totals
	bit [COUNT_PORT_W-1:0] cell_tab [BINS*BINS];
	bit [SUM_W-1:0]        row_tot [BINS];
	bit [SUM_W-1:0]        col_tot [BINS];
	bit [SUM_W-1:0]        all_tot;

	tally_t          tally_q [$];
	int              errors;
	int              idle_pct;
	int unsigned     cycle_count;
	bit              start_held;
	logic [BIN_W-1:0] last_col;
	logic [BIN_W-1:0] last_row;
	logic [PCT_W-1:0] last_x;
	logic [PCT_W-1:0] last_y;

	joint_histogram_with_marginals dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.x_percent   (x_percent),
		.y_percent   (y_percent),
		.col_select  (col_select),
		.row_select  (row_select),
		.write_count (write_count),
		.done        (done),
		.col_bin     (col_bin),
		.row_bin     (row_bin),
		.cell_count  (cell_count),
		.row_sum     (row_sum),
		.column_sum  (column_sum),
		.grand_sum   (grand_sum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random filler for fields a command ignores
	function automatic logic [PCT_W-1:0] rnd_pct();
		return PCT_W'($urandom);
	endfunction

	function automatic logic [BIN_W-1:0] rnd_bin();
		return BIN_W'($urandom);
	endfunction

	function automatic logic [COUNT_PORT_W-1:0] rnd_cnt();
		return COUNT_PORT_W'($urandom);
	endfunction

	// Map a signed percentage to its half-percent bin
	function automatic logic [BIN_W-1:0] half_percent_bin(input logic [PCT_W-1:0] v);
		logic [7:0] n;
		logic [7:0] f;
		logic [8:0] b;
		if (v == '0 || v[PCT_W-1])
			return '0;
		n = v[15:8];
		f = v[7:0];
		b = (f != 8'd0 && f <= 8'd128) ? {n, 1'b1} : {n, 1'b0};
		return (b >= BINS) ? BIN_W'(BINS - 1) : b[BIN_W-1:0];
	endfunction

	// Replace a cell count and move the totals by the difference
	task automatic put_count(input logic [BIN_W-1:0] c, input logic [BIN_W-1:0] r,
			input logic [COUNT_PORT_W-1:0] newv);
		logic [SUM_W-1:0] diff;
		diff = SUM_W'(newv) - SUM_W'(cell_tab[{r, c}]);
		cell_tab[{r, c}] = newv;
		row_tot[r] += diff;
		col_tot[c] += diff;
		all_tot += diff;
	endtask

	// Apply one accepted command to the shadow table and queue its result
	task automatic tally_update(input logic [FUNC_W-1:0] f, input logic [PCT_W-1:0] x,
			input logic [PCT_W-1:0] y, input logic [BIN_W-1:0] cs, input logic [BIN_W-1:0] rs,
			input logic [COUNT_PORT_W-1:0] wc);
		logic [BIN_W-1:0] c;
		logic [BIN_W-1:0] r;
		tally_t t;
		if (f == FUNC_OBSERVE) begin
			c = half_percent_bin(x);
			r = half_percent_bin(y);
			// Saturated cells hold, totals stay put
			if (cell_tab[{r, c}] != COUNT_MAX)
				put_count(c, r, cell_tab[{r, c}] + 1'b1);
		end else begin
			c = cs;
			r = rs;
			if (f == FUNC_WRITE)
				put_count(c, r, wc);
		end
		last_col = c;
		last_row = r;
		t.col = c;
		t.row = r;
		t.cnt = cell_tab[{r, c}];
		t.rsum = row_tot[r];
		t.csum = col_tot[c];
		t.gsum = all_tot;
		tally_q = {tally_q, t};
	endtask

	// Drive one command beat, wait for acceptance, then idle at random
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [PCT_W-1:0] x,
			input logic [PCT_W-1:0] y, input logic [BIN_W-1:0] cs, input logic [BIN_W-1:0] rs,
			input logic [COUNT_PORT_W-1:0] wc);
		int gap;
		bit taken;
		start <= 1'b1;
		start_held = 1'b1;
		func <= f;
		x_percent <= x;
		y_percent <= y;
		col_select <= cs;
		row_select <= rs;
		write_count <= wc;
		// Busy is settled by the falling edge; a low busy there means the next rising edge takes the beat
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		tally_update(f, x, y, cs, rs, wc);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			start_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [SUM_W-1:0] exp_v,
			input logic [SUM_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Compare each result beat with the oldest pending one, sampled mid-cycle
	always @(negedge clk) begin : result_check
		tally_t want;
		if (done) begin
			if (tally_q.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual col %0h row %0h",
					$time, col_bin, row_bin);
				errors++;
			end else begin
				want = tally_q.pop_front();
				check_field("col_bin", SUM_W'(want.col), SUM_W'(col_bin));
				check_field("row_bin", SUM_W'(want.row), SUM_W'(row_bin));
				check_field("cell_count", SUM_W'(want.cnt), SUM_W'(cell_count));
				check_field("row_sum", want.rsum, row_sum);
				check_field("column_sum", want.csum, column_sum);
				check_field("grand_sum", want.gsum, grand_sum);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("joint_histogram_with_marginals_test: errors");
			$finish;
		end
	end

	// Bin edges, saturation, spare code and back-to-back hits on one cell
	task automatic test_directed();
		idle_pct = 0;
		send_cmd(FUNC_READ, rnd_pct(), rnd_pct(), 8'd0, 8'd0, rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h0000, 16'h0000, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h8000, 16'hFFFF, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h7FFF, 16'h7F80, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h0001, 16'h0080, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h0081, 16'h0100, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_OBSERVE, 16'h00FF, 16'h0181, rnd_bin(), rnd_bin(), rnd_cnt());
		// Saturate the top corner, then observe into it twice
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'hFF, 8'hFF, COUNT_MAX);
		repeat (2) send_cmd(FUNC_OBSERVE, 16'h7F80, 16'h7F80, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'hFF, 8'hFF, 24'd0);
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'd0, 8'd0, COUNT_MAX);
		send_cmd(FUNC_SPARE, rnd_pct(), rnd_pct(), 8'd0, 8'd0, rnd_cnt());
		send_cmd(FUNC_READ, rnd_pct(), rnd_pct(), 8'hFF, 8'd0, rnd_cnt());
		// Write then hit the same cell three beats in a row
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'd7, 8'd3, 24'd5);
		repeat (3) send_cmd(FUNC_OBSERVE, 16'h0301, 16'h0101, rnd_bin(), rnd_bin(), rnd_cnt());
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'd7, 8'd3, 24'h123456);
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'd7, 8'd3, 24'h000001);
		send_cmd(FUNC_READ, rnd_pct(), rnd_pct(), 8'd7, 8'd3, rnd_cnt());
		send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), 8'd0, 8'hFF, COUNT_MAX);
		send_cmd(FUNC_OBSERVE, 16'h0000, 16'h7F80, rnd_bin(), rnd_bin(), rnd_cnt());
	endtask

	// Fill more than a full row with maximum counts so the grand total wraps
	task automatic test_grand_wrap();
		idle_pct = 35;
		for (int i = 0; i < 300; i++)
			send_cmd(FUNC_WRITE, rnd_pct(), rnd_pct(), i[7:0], 8'(200 + i / 256), COUNT_MAX);
		send_cmd(FUNC_READ, rnd_pct(), rnd_pct(), 8'd0, 8'd200, rnd_cnt());
	endtask

	// Mixed traffic, biased toward a few cells so hits repeat
	task automatic test_random(input int n_items, input int pct);
		int kind;
		int sub;
		logic [PCT_W-1:0] x;
		logic [PCT_W-1:0] y;
		logic [BIN_W-1:0] cs;
		logic [BIN_W-1:0] rs;
		logic [COUNT_PORT_W-1:0] wc;
		idle_pct = pct;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(0, 99);
			sub = $urandom_range(0, 9);
			x = rnd_pct();
			y = rnd_pct();
			wc = rnd_cnt();
			// Pick a recent cell, a small corner or anywhere
			if (sub < 5) begin
				cs = last_col;
				rs = last_row;
			end else if (sub < 8) begin
				cs = BIN_W'($urandom_range(0, 15));
				rs = BIN_W'($urandom_range(0, 15));
			end else begin
				cs = rnd_bin();
				rs = rnd_bin();
			end
			if (kind < 50) begin
				if (sub < 4) begin
					x = PCT_W'($urandom_range(0, 1100)) - 16'd64;
					y = PCT_W'($urandom_range(0, 1100)) - 16'd64;
				end else if (sub < 6) begin
					x = last_x;
					y = last_y;
				end
				last_x = x;
				last_y = y;
				send_cmd(FUNC_OBSERVE, x, y, rnd_bin(), rnd_bin(), rnd_cnt());
			end else if (kind < 65) begin
				send_cmd(FUNC_READ, x, y, cs, rs, wc);
			end else if (kind < 70) begin
				send_cmd(FUNC_SPARE, x, y, cs, rs, wc);
			end else begin
				case ($urandom_range(0, 3))
					0: wc = COUNT_MAX;
					1: wc = COUNT_PORT_W'($urandom_range(0, 3));
					default: wc = rnd_cnt();
				endcase
				send_cmd(FUNC_WRITE, x, y, cs, rs, wc);
			end
		end
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		start_held = 1'b0;
		last_col = '0;
		last_row = '0;
		last_x = '0;
		last_y = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_OBSERVE;
		x_percent <= '0;
		y_percent <= '0;
		col_select <= '0;
		row_select <= '0;
		write_count <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_grand_wrap();
		test_random(190, 0);
		test_random(190, 49);
		test_random(190, 35);
		test_random(180, 0);

		// Stop sending, drain the pending results
		if (start_held)
			start <= 1'b0;
		while (tally_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("joint_histogram_with_marginals_test: clean");
		else
			$display("joint_histogram_with_marginals_test: errors");
		$finish;
	end

endmodule
